@@ design/tes_pkg.sv @@
// ----------------------------------------------------------------------------
// tes_pkg
// Types and constants shared by the element scanner modules.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int FILTER_SLOTS_DEF   = 4;
  localparam int MIN_ELEM_BYTES_DEF = 2;
  localparam int TYPE_REGS          = 4;
  localparam int QUEUE_DEPTH        = 4;  // power of two
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] NO_MATCH   = 3'd4;

  typedef enum logic [2:0] {
    CFG_FILTER_COUNT = 3'd0,
    CFG_FILTER_A     = 3'd1,
    CFG_FILTER_B     = 3'd2,
    CFG_FILTER_C     = 3'd3,
    CFG_FILTER_D     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_TYPE    = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_DATA    = 2'd3
  } scan_phase_e;

  typedef enum logic {
    KIND_ELEMENT = 1'b0,
    KIND_END     = 1'b1
  } result_kind_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       first_byte;
    logic [7:0] body_length;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] element_offset;
    logic [6:0] first_type_char;
    logic [7:0] type_byte_count;
    logic [7:0] data_byte_count;
    logic [2:0] match_slot;
    logic [3:0] match_mask;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                filter_count;
    logic [TYPE_REGS-1:0][6:0] filter_type;
  } filter_cfg_t;

  // Results produced by one accepted item, r0 first
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } scan_res_t;

endpackage

@@ design/tes_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tes_cfg_regs
// Filter configuration registers, written through the config channel.
// ----------------------------------------------------------------------------
module tes_cfg_regs
  import tes_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output filter_cfg_t filter_cfg_o
);

  filter_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_COUNT: cfg_d.filter_count   = cfg_data_i[2:0];
        CFG_FILTER_A:     cfg_d.filter_type[0] = cfg_data_i[6:0];
        CFG_FILTER_B:     cfg_d.filter_type[1] = cfg_data_i[6:0];
        CFG_FILTER_C:     cfg_d.filter_type[2] = cfg_data_i[6:0];
        CFG_FILTER_D:     cfg_d.filter_type[3] = cfg_data_i[6:0];
        default:          cfg_d = cfg_q;  // unmapped index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign filter_cfg_o = cfg_q;

endmodule

@@ design/tes_scan_ctrl.sv @@
// ----------------------------------------------------------------------------
// tes_scan_ctrl
// Element walker: tracks the header/data phase of each element and forms
// element and end records from the accepted body bytes.
// ----------------------------------------------------------------------------
module tes_scan_ctrl
  import tes_pkg::*;
#(
  parameter int FILTER_SLOTS   = FILTER_SLOTS_DEF,
  parameter int MIN_ELEM_BYTES = MIN_ELEM_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  in_item_t    item_i,
  input  filter_cfg_t filter_cfg_i,
  output scan_res_t   res_o
);

  localparam int         SlotLimit = (FILTER_SLOTS < TYPE_REGS) ? FILTER_SLOTS : TYPE_REGS;
  localparam logic [7:0] MinElem   = 8'(MIN_ELEM_BYTES);

  scan_phase_e phase_q, phase_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  total_q, total_d;
  logic [7:0]  tcnt_q, tcnt_d;
  logic [6:0]  fc_q, fc_d;
  logic [7:0]  start_q, start_d;
  logic [7:0]  dleft_q, dleft_d;
  logic [3:0]  mask_q, mask_d;

  logic [2:0]  slot;
  out_item_t   elem_rec, end_rec;
  logic        elem_v, end_v;

  // lowest enabled slot whose type equals the held first character
  always_comb begin
    slot = NO_MATCH;
    for (int i = SlotLimit - 1; i >= 0; i--) begin
      if ((3'(i) < filter_cfg_i.filter_count) && (filter_cfg_i.filter_type[i] == fc_q)) begin
        slot = 3'(i);
      end
    end
  end

  always_comb begin
    logic [8:0]  rem;
    scan_phase_e ph;
    phase_d = phase_q;
    pos_d   = pos_q;
    total_d = total_q;
    tcnt_d  = tcnt_q;
    fc_d    = fc_q;
    start_d = start_q;
    dleft_d = dleft_q;
    mask_d  = mask_q;
    elem_v  = 1'b0;
    end_v   = 1'b0;
    rem     = '0;
    ph      = PH_STOPPED;

    if (accept_i) begin
      ph = phase_q;
      if (item_i.first_byte) begin
        total_d = item_i.body_length;
        pos_d   = '0;
        mask_d  = '0;
        if (item_i.body_length < MinElem) begin
          end_v   = 1'b1;
          phase_d = PH_STOPPED;
          ph      = PH_STOPPED;
        end else begin
          phase_d = PH_TYPE;
          ph      = PH_TYPE;
          start_d = '0;
          tcnt_d  = '0;
        end
      end

      unique case (ph)
        PH_TYPE: begin
          if (tcnt_d == 8'd0) fc_d = item_i.body_byte[6:0];
          if (tcnt_d != 8'hFF) tcnt_d = tcnt_d + 8'd1;
          if (!item_i.body_byte[7]) phase_d = PH_LENGTH;
          pos_d = pos_d + 8'd1;
          if (pos_d >= total_d) begin
            end_v   = 1'b1;
            phase_d = PH_STOPPED;
          end
        end
        PH_LENGTH, PH_DATA: begin
          if (ph == PH_LENGTH) begin
            dleft_d = item_i.body_byte;
            elem_v  = 1'b1;
            if (slot != NO_MATCH) mask_d = mask_d | (4'b0001 << slot[1:0]);
            phase_d = PH_DATA;
          end else begin
            dleft_d = dleft_q - 8'd1;
          end
          pos_d = pos_d + 8'd1;
          rem   = {1'b0, total_d} - {1'b0, pos_d};
          if (dleft_d == 8'd0) begin
            // element consumed: end if too few bytes remain for another
            if (!rem[8] && (rem[7:0] < MinElem)) begin
              end_v   = 1'b1;
              phase_d = PH_STOPPED;
            end else begin
              phase_d = PH_TYPE;
              start_d = pos_d;
              tcnt_d  = '0;
            end
          end else if (pos_d >= total_d) begin
            end_v   = 1'b1;
            phase_d = PH_STOPPED;
          end
        end
        default: ;  // stopped: byte ignored
      endcase
    end
  end

  always_comb begin
    elem_rec                 = '0;
    elem_rec.result_kind     = KIND_ELEMENT;
    elem_rec.element_offset  = start_q;
    elem_rec.first_type_char = fc_q;
    elem_rec.type_byte_count = tcnt_q;
    elem_rec.data_byte_count = item_i.body_byte;
    elem_rec.match_slot      = slot;
    elem_rec.last_of_run     = !end_v;

    end_rec             = '0;
    end_rec.result_kind = KIND_END;
    end_rec.match_mask  = mask_d;
    end_rec.last_of_run = 1'b1;

    res_o.count = {1'b0, elem_v} + {1'b0, end_v};
    res_o.r0    = elem_v ? elem_rec : end_rec;
    res_o.r1    = end_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STOPPED;
      pos_q   <= '0;
      total_q <= '0;
      tcnt_q  <= '0;
      fc_q    <= '0;
      start_q <= '0;
      dleft_q <= '0;
      mask_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      total_q <= total_d;
      tcnt_q  <= tcnt_d;
      fc_q    <= fc_d;
      start_q <= start_d;
      dleft_q <= dleft_d;
      mask_q  <= mask_d;
    end
  end

endmodule

@@ design/tes_result_queue.sv @@
// ----------------------------------------------------------------------------
// tes_result_queue
// Small result queue: takes up to two records a cycle, hands out one while out_stall_i is low.
// ----------------------------------------------------------------------------
module tes_result_queue
  import tes_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  scan_res_t res_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  out_item_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]   cnt_q;
  logic                     pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for two records must be there before an item is taken
  assign full_o      = (cnt_q > QUEUE_CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (res_i.count != 2'd0) mem_q[wr_ptr_q] <= res_i.r0;
    if (res_i.count == 2'd2) mem_q[wr_ptr_q + QUEUE_PTR_W'(1)] <= res_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(res_i.count);
      if (pop) rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      cnt_q <= cnt_q + QUEUE_CNT_W'(res_i.count) - QUEUE_CNT_W'(pop);
    end
  end

endmodule

@@ design/tlv_element_scanner_core.sv @@
// ----------------------------------------------------------------------------
// tlv_element_scanner_core
// Type-length-value element scanner with four type filters.
// ----------------------------------------------------------------------------
// Records of a taken item are formed combinationally and registered in the result queue.
// Throughput: one body byte per cycle while in_stall_o is low; a length byte that
//   also ends the scan yields two records, both written at once into a 4-entry queue.
// Reset: asynchronous, clears scan state, filter registers and the queue.
module tlv_element_scanner_core
  import tes_pkg::*;
#(
  parameter int FILTER_SLOTS   = FILTER_SLOTS_DEF,
  parameter int MIN_ELEM_BYTES = MIN_ELEM_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  filter_cfg_t filter_cfg;
  scan_res_t   scan_res;
  logic        accept;

  assign accept = in_valid_i && !in_stall_o;

  tes_cfg_regs u_cfg_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .filter_cfg_o (filter_cfg)
  );

  tes_scan_ctrl #(
    .FILTER_SLOTS   (FILTER_SLOTS),
    .MIN_ELEM_BYTES (MIN_ELEM_BYTES)
  ) u_scan_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .filter_cfg_i (filter_cfg),
    .res_o        (scan_res)
  );

  tes_result_queue u_result_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (scan_res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
